// ----- rtl/shuffled_lehmer_random_generator_core_defines.svh -----
// ============================================================================
// Shuffled Lehmer generator assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ============================================================================
`ifndef SHUFFLED_LEHMER_RANDOM_GENERATOR_CORE_DEFINES_SVH
`define SHUFFLED_LEHMER_RANDOM_GENERATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLRG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLRG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/slrg_pkg.sv -----
// ============================================================================
// Shuffled Lehmer generator package
// Controller states, command and status bundles, and generator arithmetic.
// ============================================================================
package slrg_pkg;

    localparam logic [30:0] LCG_MOD      = 31'h7FFF_FFFF;
    localparam logic [14:0] LCG_MULT     = 15'd16807;
    localparam int          WARMUP_STEPS = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WARM_MUL,
        ST_WARM_RED,
        ST_FILL_MUL,
        ST_FILL_RED,
        ST_DRAW_MUL,
        ST_READ,
        ST_DONE
    } slrg_state_t;

    typedef struct packed {
        logic load_seed;   // load the clamped seed into the generator
        logic seed_one;    // seed with 1 instead of the seed field
        logic mul;         // register generator value times the multiplier
        logic red;         // reduce the product into the generator value
        logic fill_we;     // write the reduced value into the table
        logic fill_last;   // last fill step: reduced value becomes last output
        logic pick_slot;   // register the table slot chosen by the last output
        logic draw_done;   // swap the chosen slot and load the result
    } slrg_cmd_t;

    typedef struct packed {
        logic last_zero;   // generator has never been seeded
    } slrg_stat_t;

    // Folding reduction modulo 2^31-1 of a 46-bit product.
    function automatic logic [30:0] lehmer_reduce(input logic [45:0] p);
        logic [31:0] s;
        s = {1'b0, p[30:0]} + {17'b0, p[45:31]};
        if (s >= {1'b0, LCG_MOD}) begin
            s = s - {1'b0, LCG_MOD};
        end
        return s[30:0];
    endfunction

    // Seeds congruent to zero would lock the generator at zero.
    function automatic logic [30:0] seed_clamp(input logic [30:0] s);
        return ((s == 31'd0) || (s == LCG_MOD)) ? 31'd1 : s;
    endfunction

endpackage

// ----- rtl/slrg_ram.sv -----
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module slrg_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/slrg_datapath.sv -----
// ============================================================================
// Shuffled Lehmer generator datapath
// Generator register, multiply and reduce steps, slot selection and table.
// ============================================================================
module slrg_datapath #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  slrg_pkg::slrg_cmd_t              cmd,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   idx,
    input  logic [30:0]                      seed,
    output slrg_pkg::slrg_stat_t             stat,
    output logic [30:0]                      sample,
    output logic [30:0]                      generator_value
);
    import slrg_pkg::*;

    localparam int IDXW = $clog2(TABLE_DEPTH);
    localparam int PW   = 31 + IDXW;

    logic [30:0]     lehmer_reg, lehmer_next;
    logic [30:0]     last_reg, last_next;
    logic [45:0]     prod_reg, prod_next;
    logic [IDXW-1:0] quo_reg, quo_next;
    logic [30:0]     sample_reg, sample_next;
    logic [30:0]     gen_reg, gen_next;
    logic [30:0]     reduced;
    logic [PW-1:0]   scaled;
    logic [IDXW-1:0] quo_est;
    logic [30:0]     quo_bias;
    logic [IDXW-1:0] quo_calc;
    logic [IDXW-1:0] slot;
    logic            ram_we;
    logic [IDXW-1:0] ram_waddr;
    logic [30:0]     ram_wdata;
    logic [30:0]     ram_rdata;

    assign reduced = lehmer_reduce(prod_reg);

    // The slot divisor is 2^31 + TABLE_DEPTH - 2. Dividing by 2^31 alone
    // gives an estimate that is exact or one too high; the estimate is
    // kept when the low part of the scaled value covers the extra divisor
    // term, otherwise it drops by one.
    assign scaled   = PW'(last_reg) * PW'(TABLE_DEPTH);
    assign quo_est  = scaled[PW-1:31];
    assign quo_bias = 31'(quo_est) * 31'(TABLE_DEPTH - 2);
    assign quo_calc = (scaled[30:0] >= quo_bias) ? quo_est : quo_est - IDXW'(1);
    assign slot     = (quo_reg > IDXW'(TABLE_DEPTH - 1)) ? IDXW'(TABLE_DEPTH - 1) : quo_reg;

    always_comb
    begin
        lehmer_next = lehmer_reg;
        last_next   = last_reg;
        prod_next   = prod_reg;
        quo_next    = quo_reg;
        sample_next = sample_reg;
        gen_next    = gen_reg;
        if (cmd.load_seed)
        begin
            lehmer_next = cmd.seed_one ? 31'd1 : seed_clamp(seed);
        end
        if (cmd.mul)
        begin
            prod_next = 46'(lehmer_reg) * 46'(LCG_MULT);
        end
        if (cmd.red)
        begin
            lehmer_next = reduced;
        end
        if (cmd.fill_last)
        begin
            last_next = reduced;
        end
        if (cmd.pick_slot)
        begin
            quo_next = quo_calc;
        end
        if (cmd.draw_done)
        begin
            last_next   = ram_rdata;
            sample_next = ram_rdata;
            gen_next    = lehmer_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lehmer_reg <= '0;
            last_reg   <= '0;
        end
        else
        begin
            lehmer_reg <= lehmer_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        quo_reg    <= quo_next;
        sample_reg <= sample_next;
        gen_reg    <= gen_next;
    end

    // Fill steps write from the top entry down; a draw refills its slot.
    always_comb
    begin
        ram_we    = cmd.fill_we || cmd.draw_done;
        ram_waddr = cmd.fill_we ? idx : slot;
        ram_wdata = cmd.fill_we ? reduced : lehmer_reg;
    end

    slrg_ram #(
        .WIDTH (31),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    assign stat.last_zero  = (last_reg == 31'd0);
    assign sample          = sample_reg;
    assign generator_value = gen_reg;
endmodule

// ----- rtl/slrg_ctrl.sv -----
// ============================================================================
// Shuffled Lehmer generator controller
// Sequences reseed, warm-up, table fill and draw; owns the output valid.
// ============================================================================
`include "shuffled_lehmer_random_generator_core_defines.svh"

module slrg_ctrl #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    output logic                             out_valid,
    input  logic                             out_stall,
    input  slrg_pkg::slrg_stat_t             stat,
    output slrg_pkg::slrg_cmd_t              cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0]   idx
);
    import slrg_pkg::*;

    localparam int IDXW = $clog2(TABLE_DEPTH);
    localparam int CNTW = (IDXW > 3) ? IDXW : 3;

    slrg_state_t     state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;
    logic            accept;
    logic            load_out;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // Next state and step counter.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = '0;
                    state_next = (mode || stat.last_zero) ? ST_WARM_MUL : ST_DRAW_MUL;
                end
            end
            ST_WARM_MUL:
            begin
                state_next = ST_WARM_RED;
            end
            ST_WARM_RED:
            begin
                if (cnt_reg == CNTW'(WARMUP_STEPS - 1))
                begin
                    cnt_next   = CNTW'(TABLE_DEPTH - 1);
                    state_next = ST_FILL_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg + CNTW'(1);
                    state_next = ST_WARM_MUL;
                end
            end
            ST_FILL_MUL:
            begin
                state_next = ST_FILL_RED;
            end
            ST_FILL_RED:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DRAW_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNTW'(1);
                    state_next = ST_FILL_MUL;
                end
            end
            ST_DRAW_MUL:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath commands. The slot is picked while the draw's product is
    // formed; the read cycle then reduces that product and reads the slot.
    always_comb
    begin
        cmd           = '0;
        cmd.load_seed = accept && (mode || stat.last_zero);
        cmd.seed_one  = !mode;
        cmd.mul       = (state_reg == ST_WARM_MUL) || (state_reg == ST_FILL_MUL) ||
                        (state_reg == ST_DRAW_MUL);
        cmd.red       = (state_reg == ST_WARM_RED) || (state_reg == ST_FILL_RED) ||
                        (state_reg == ST_READ);
        cmd.fill_we   = (state_reg == ST_FILL_RED);
        cmd.fill_last = (state_reg == ST_FILL_RED) && (cnt_reg == '0);
        cmd.pick_slot = (state_reg == ST_DRAW_MUL);
        cmd.draw_done = load_out;
    end

    always_comb
    begin
        out_valid_next = load_out ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign idx       = cnt_reg[IDXW-1:0];

    `SLRG_ASSERT_SAME(a_seed_on_accept, cmd.load_seed, in_valid && !in_stall, "seed load without an accepted item")
    `SLRG_ASSERT_NEXT(a_reseed_starts, in_valid && !in_stall && mode, state_reg == ST_WARM_MUL, "reseed did not start warm-up")
    `SLRG_ASSERT_NEXT(a_draw_read, state_reg == ST_DRAW_MUL, state_reg == ST_READ, "no table read")
    `SLRG_ASSERT_SAME(a_out_from_done, $rose(out_valid_reg), $past(state_reg == ST_DONE), "result shown outside a finished draw")
endmodule

// ----- rtl/shuffled_lehmer_random_generator_core.sv -----
// ============================================================================
// Shuffled Lehmer random generator core
// Minimal standard Lehmer generator behind a Bays-Durham shuffle table.
// ============================================================================
// A draw passes through a multiply state, a read state and a done state after
//   the item is accepted; a new item is taken only once the core is idle again.
// A reseed, or the first draw after reset, first runs the warm-up steps and then
//   one step per table entry: each generator step is one multiply and one reduce.
// Reset clears control state and marks the generator unseeded; the table is
//   not cleared, as seeding always fills it before it is read.
module shuffled_lehmer_random_generator_core #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [30:0] seed,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [30:0] sample,
    output logic [30:0] generator_value
);
    import slrg_pkg::*;

    localparam int IDXW = $clog2(TABLE_DEPTH);

    // The controller walks the item through its steps and the datapath
    // carries them out; they share only the command and status bundles and
    // the step counter, which doubles as the table fill index. The table
    // slot of a draw is picked from the last output while the generator
    // product is formed.
    slrg_cmd_t       cmd;
    slrg_stat_t      stat;
    logic [IDXW-1:0] idx;

    slrg_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .idx       (idx)
    );

    // The result sits in an output register, so a new item is taken while
    // an earlier result still waits; a draw finishes only once that
    // register is free.
    slrg_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .idx             (idx),
        .seed            (seed),
        .stat            (stat),
        .sample          (sample),
        .generator_value (generator_value)
    );
endmodule

// ----- dv/shuffled_lehmer_random_generator_core_tb.sv -----
// ============================================================================
// Shuffled Lehmer random generator core testbench
// Sends draw and reseed items through the valid/stall input channel while the
// sender idles in bursts and the receiver stalls on its own pattern. A local
// model of the 16807 mod 2^31-1 generator and its 32-entry shuffle table
// predicts every result, and each accepted result is checked field by field.
// ============================================================================
module shuffled_lehmer_random_generator_core_tb;

    localparam int              TABLE_DEPTH  = 32;
    localparam int              WARMUP_DRAWS = 8;
    localparam longint unsigned MODULUS      = 64'd2147483647;
    localparam longint unsigned MULTIPLIER   = 64'd16807;
    localparam logic [30:0]     SEED_MOD     = 31'h7FFF_FFFF;
    localparam logic [30:0]     SEED_TOP     = 31'h7FFF_FFFE;
    localparam int              RANDOM_ITEMS = 360;
    localparam int              DRAIN_CYCLES = 120;

    // Shapes of the receiver's back-pressure.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_LONG,
        STALL_TOGGLE
    } stall_style_t;

    typedef struct packed {
        logic [30:0] sample;
        logic [30:0] generator_value;
    } draw_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        in_mode = 1'b0;
    logic [30:0] in_seed = 31'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [30:0] sample;
    logic [30:0] generator_value;

    // Model of the generator state, advanced once per accepted item. A zero
    // last output marks the generator as not yet seeded.
    logic [30:0] model_lehmer = 31'd0;
    logic [30:0] model_table [TABLE_DEPTH];
    logic [30:0] model_last = 31'd0;

    // Draws accepted by the block whose results have not arrived yet.
    draw_result_t pending_draws [$];

    int mismatch_count = 0;
    int items_accepted = 0;
    int reseed_items   = 0;
    int draws_checked  = 0;

    // Sender burst shaping; the tests may switch the gaps off.
    bit sender_gaps    = 1'b1;
    int burst_left     = 0;

    // Receiver stall pattern; the tests may switch it off.
    bit           rx_stalls      = 1'b1;
    stall_style_t stall_style    = STALL_NONE;
    int           stall_window   = 0;
    int           stall_run      = 0;

    shuffled_lehmer_random_generator_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (in_mode),
        .seed           (in_seed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sample         (sample),
        .generator_value(generator_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // One Lehmer step, done as a plain 64-bit product and remainder.
    function automatic logic [30:0] lehmer_advance(input logic [30:0] x);
        longint unsigned product;
        product = {33'd0, x} * MULTIPLIER;
        return 31'(product % MODULUS);
    endfunction

    // Reseeding clamps seeds congruent to zero to one, throws away the
    // warm-up steps, and fills the shuffle table from the top entry down.
    function automatic void reseed_shuffle_table(input logic [30:0] s);
        logic [30:0] x;
        int          n;
        x = ((s == 31'd0) || (s == SEED_MOD)) ? 31'd1 : s;
        for (n = 0; n < WARMUP_DRAWS; n++)
        begin
            x = lehmer_advance(x);
        end
        for (n = TABLE_DEPTH - 1; n >= 0; n--)
        begin
            x = lehmer_advance(x);
            model_table[n] = x;
        end
        model_lehmer = x;
        model_last   = model_table[0];
    endfunction

    // Works out the result of one accepted item and updates the model.
    function automatic draw_result_t predict_draw(input logic m, input logic [30:0] s);
        draw_result_t    r;
        longint unsigned slot;
        if (m)
        begin
            reseed_shuffle_table(s);
        end
        else if (model_last == 31'd0)
        begin
            // A draw before any seeding behaves as if seeded with one.
            reseed_shuffle_table(31'd1);
        end
        model_lehmer = lehmer_advance(model_lehmer);
        slot = ({33'd0, model_last} * 64'(TABLE_DEPTH)) /
               (64'(TABLE_DEPTH) + MODULUS - 64'd1);
        if (slot > 64'(TABLE_DEPTH - 1))
        begin
            slot = 64'(TABLE_DEPTH - 1);
        end
        model_last              = model_table[int'(slot)];
        model_table[int'(slot)] = model_lehmer;
        r.sample          = model_last;
        r.generator_value = model_lehmer;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor and scoreboard. Both channels are sampled at the same edge, so
    // the result side is checked before the new item is predicted; a result
    // can never belong to an item accepted at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        draw_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_draws.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("ERROR: unexpected result sample=%0d generator_value=%0d",
                                 sample, generator_value);
                    end
                end
                else
                begin
                    want = pending_draws.pop_front();
                    draws_checked++;
                    if (sample !== want.sample)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("ERROR: draw %0d sample expected %0d got %0d",
                                     draws_checked, want.sample, sample);
                        end
                    end
                    if (generator_value !== want.generator_value)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("ERROR: draw %0d generator_value expected %0d got %0d",
                                     draws_checked, want.generator_value, generator_value);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                items_accepted++;
                if (in_mode)
                begin
                    reseed_items++;
                end
                pending_draws.push_back(predict_draw(in_mode, in_seed));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver back-pressure. Every so often a new style is picked: no stall,
    // random stalls one time in three, long holds either way, or strict alternation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_window == 0)
        begin
            stall_style  <= stall_style_t'($urandom_range(0, 3));
            stall_window <= $urandom_range(20, 120);
        end
        else
        begin
            stall_window <= stall_window - 1;
        end
        if (!rx_stalls)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            case (stall_style)
                STALL_NONE:   out_stall <= 1'b0;
                STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
                STALL_LONG:
                begin
                    if (stall_run == 0)
                    begin
                        out_stall <= ~out_stall;
                        stall_run <= $urandom_range(1, 24);
                    end
                    else
                    begin
                        stall_run <= stall_run - 1;
                    end
                end
                default:      out_stall <= ~out_stall;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Offers one item and returns at the edge that accepts it. Items go out
    // in bursts; between bursts valid drops for a random gap and the payload
    // lines carry junk. Called only at a rising edge.
    task automatic send_item(input logic m, input logic [30:0] s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (sender_gaps)
            begin
                gap = $urandom_range(1, 12);
                in_valid <= 1'b0;
                in_mode  <= 1'($urandom);
                in_seed  <= 31'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_mode  <= m;
        in_seed  <= s;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // A random seed; one time in eight it is one of the corner values.
    function automatic logic [30:0] pick_seed();
        case ($urandom_range(0, 31))
            0:       return 31'd0;
            1:       return SEED_MOD;
            2:       return SEED_TOP;
            3:       return 31'd1;
            default: return 31'($urandom);
        endcase
    endfunction

    // The first draw straight out of reset must seed itself with one. The seed
    // field is ignored here, so it carries all ones, then all zeros, then a random value.
    task automatic test_draw_before_seed();
        send_item(1'b0, SEED_MOD);
        send_item(1'b0, 31'd0);
        send_item(1'b0, 31'($urandom));
    endtask

    // Reseeds with the zero seed, the modulus itself (both act as one), the
    // largest legal seed, one, and alternating bit patterns, each followed
    // by a plain draw with the inverted seed on the ignored field.
    task automatic test_seed_extremes();
        logic [30:0] corner_seeds [6];
        int          k;
        corner_seeds = '{31'd0, SEED_MOD, SEED_TOP, 31'd1,
                         31'h5555_5555, 31'h2AAA_AAAA};
        for (k = 0; k < 6; k++)
        begin
            send_item(1'b1, corner_seeds[k]);
            send_item(1'b0, ~corner_seeds[k]);
        end
    endtask

    // A stretch with neither side idling: items at the block's full rate,
    // with a couple of reseeds in the middle.
    task automatic test_back_to_back();
        int k;
        sender_gaps = 1'b0;
        rx_stalls   = 1'b0;
        for (k = 0; k < 40; k++)
        begin
            send_item((k == 13) || (k == 27), pick_seed());
        end
        sender_gaps = 1'b1;
        rx_stalls   = 1'b1;
    endtask

    // The bulk of the run: long random streams of draws, broken now and
    // then by a reseed, with both sides idling.
    task automatic test_random_stream();
        int k;
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            send_item(($urandom_range(0, 19) == 0), pick_seed());
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_draw_before_seed();
        test_seed_extremes();
        test_back_to_back();
        test_random_stream();

        // Stop offering items, let every outstanding draw come back, then
        // watch a little longer for any result that nobody asked for.
        in_valid <= 1'b0;
        while (pending_draws.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d items, %0d of them reseeds, and checked %0d draws.",
                 items_accepted, reseed_items, draws_checked);
        $display("Seeds included zero, the modulus, the top legal value and bit patterns.");
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("Total mismatches: %0d", mismatch_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("Timeout with %0d draws still outstanding.", pending_draws.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/slrg_pkg.sv
rtl/slrg_ram.sv
rtl/slrg_datapath.sv
rtl/slrg_ctrl.sv
rtl/shuffled_lehmer_random_generator_core.sv
dv/shuffled_lehmer_random_generator_core_tb.sv
